// ===== sv/base64_stream_decoder_assert.svh =====
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// check a property on every clock edge outside reset
`define B64SD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("base64 stream decoder check failed");

// check a property on every clock edge, reset included
`define B64SD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("base64 stream decoder check failed");

`endif

// ===== sv/b64sd_pkg.sv =====
// package for the base64 stream decoder: widths, character codes and alphabet lookup
package b64sd_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SextW  = 6;
  localparam int unsigned AccW   = 12;
  localparam int unsigned HeldW  = 4;
  localparam int unsigned CountW = 20;
  localparam int unsigned TdataW = 32;

  localparam logic [CountW-1:0] MaxBytesReset = 20'hFFFFF;

  localparam logic [CharW-1:0] ChPad   = 8'h3D;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChSlash = 8'h2F;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoZ   = 8'h7A;
  localparam logic [CharW-1:0] ChDig0  = 8'h30;
  localparam logic [CharW-1:0] ChDig9  = 8'h39;

  typedef struct packed {
    logic             ok;
    logic [SextW-1:0] value;
  } sextet_t;

  // whitespace and all other foreign characters come back as not ok
  function automatic sextet_t sextet_of(input logic [CharW-1:0] c);
    sextet_t r;
    r.ok    = 1'b1;
    r.value = '0;
    if (c >= ChUpA && c <= ChUpZ) begin
      r.value = SextW'(c - ChUpA);
    end else if (c >= ChLoA && c <= ChLoZ) begin
      r.value = SextW'(c - ChLoA + 8'd26);
    end else if (c >= ChDig0 && c <= ChDig9) begin
      r.value = SextW'(c - ChDig0 + 8'd52);
    end else if (c == ChPlus) begin
      r.value = 6'd62;
    end else if (c == ChSlash) begin
      r.value = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/base64_stream_decoder.sv =====
// base64 stream decoder top level: character input, byte and done result output
//
// Decodes one base64 text character per cycle while results are not held back
// by m_axis_tready. A character enters the input register, is decoded
// against the running stream state, and the result, if any, moves into the
// output register; a new character can be taken every cycle unless a result
// waits on m_axis_tready, so the sustained rate is one character per clock,
// set by the single decode step between the two registers. Characters outside
// the alphabet (whitespace included) give no result; a '=' stops decoding
// until the character marked with tlast, which always gives a done result
// carrying the byte count (zero after overflow) and clears the stream state.
// The limit register may be written only while no request is in flight.
module base64_stream_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_wr_en_i,
  input  logic [b64sd_pkg::CountW-1:0]      cfg_wr_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // text_char
  input  logic [b64sd_pkg::CharW-1:0]       s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_byte [7:0], byte_count [27:8], overflow [28], zero [31:29]
  output logic [b64sd_pkg::TdataW-1:0]      m_axis_tdata,
  // byte_valid
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int unsigned CharW  = b64sd_pkg::CharW;
  localparam int unsigned AccW   = b64sd_pkg::AccW;
  localparam int unsigned HeldW  = b64sd_pkg::HeldW;
  localparam int unsigned CountW = b64sd_pkg::CountW;

  logic [CountW-1:0] max_bytes_q;

  logic              in_valid_q;
  logic [CharW-1:0]  in_char_q;
  logic              in_last_q;

  logic [AccW-1:0]   acc_q, acc_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [CountW-1:0] emitted_q, emitted_d;
  logic              pad_q, pad_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_bvalid_q, out_bvalid_d;
  logic              out_done_q;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic              out_ovf_q, out_ovf_d;

  b64sd_pkg::sextet_t sext;
  logic [AccW-1:0]    acc_shift;
  logic [HeldW-1:0]   held_add;
  logic               active;
  logic               emit_try;
  logic               produce;
  logic               advance;

  // decode step
  always_comb begin
    sext         = b64sd_pkg::sextet_of(in_char_q);
    active       = !pad_q && !ovf_q;
    acc_shift    = {acc_q[AccW-7:0], sext.value};
    held_add     = held_q + HeldW'(6);
    acc_d        = acc_q;
    held_d       = held_q;
    emitted_d    = emitted_q;
    pad_d        = pad_q;
    ovf_d        = ovf_q;
    out_byte_d   = '0;
    out_bvalid_d = 1'b0;
    emit_try     = 1'b0;
    if (active) begin
      if (in_char_q == b64sd_pkg::ChPad) begin
        pad_d = 1'b1;
      end else if (sext.ok) begin
        acc_d    = acc_shift;
        emit_try = (held_add >= HeldW'(8));
        held_d   = emit_try ? held_add - HeldW'(8) : held_add;
        if (emit_try) begin
          if (emitted_q < max_bytes_q) begin
            out_byte_d   = 8'(acc_shift >> held_d);
            out_bvalid_d = 1'b1;
            emitted_d    = emitted_q + CountW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
    end
    out_count_d = (in_last_q && !ovf_d) ? emitted_d : '0;
    out_ovf_d   = in_last_q && ovf_d;
    produce     = out_bvalid_d || in_last_q;
  end

  assign advance       = in_valid_q && (!produce || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= b64sd_pkg::MaxBytesReset;
    end else if (cfg_wr_en_i) begin
      max_bytes_q <= cfg_wr_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      held_q    <= '0;
      emitted_q <= '0;
      pad_q     <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (advance) begin
      if (in_last_q) begin
        acc_q     <= '0;
        held_q    <= '0;
        emitted_q <= '0;
        pad_q     <= 1'b0;
        ovf_q     <= 1'b0;
      end else begin
        acc_q     <= acc_d;
        held_q    <= held_d;
        emitted_q <= emitted_d;
        pad_q     <= pad_d;
        ovf_q     <= ovf_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_byte_q   <= out_byte_d;
      out_bvalid_q <= out_bvalid_d;
      out_done_q   <= in_last_q;
      out_count_q  <= out_count_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_ovf_q, out_count_q, out_byte_q};
  assign m_axis_tuser  = out_bvalid_q;
  assign m_axis_tlast  = out_done_q;

`include "base64_stream_decoder_assert.svh"

  // held bits only ever take even values no greater than six
  `B64SD_ASSERT(a_held_even, clk_i, rst_ni, held_q[0] == 1'b0 && held_q <= HeldW'(6))
  // a last character leaves a cleared stream behind
  `B64SD_ASSERT(a_last_clears, clk_i, rst_ni,
    advance && in_last_q |=> acc_q == '0 && held_q == '0 && emitted_q == '0 && !pad_q && !ovf_q)
  // no byte is emitted once overflow or padding has been seen
  `B64SD_ASSERT(a_no_byte_after_stop, clk_i, rst_ni,
    advance && (pad_q || ovf_q) |-> !out_bvalid_d)

endmodule
